// ===== rtl/tks_pkg.sv =====
// shared types and codes for the top-k score selector
`timescale 1ns / 1ps
package tks_pkg;

	localparam int unsigned ENTRIES  = 64;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned POS_W    = 6;
	localparam int unsigned SCORE_W  = 32;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned COUNT_W  = 7;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 7;

	typedef enum logic [OP_W-1:0] {
		OP_PUT     = 2'd0,
		OP_COMPACT = 2'd1,
		OP_FIND    = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_SLOT_RANGE  = 3'd1,
		ST_SLOT_FILLED = 3'd2,
		ST_NOT_FULL    = 3'd3,
		ST_START_LARGE = 3'd4,
		ST_NO_RESULT   = 3'd5,
		ST_INDEX_LARGE = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SORT_DESC  = 2'd0,
		REG_TABLE_SIZE = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [TAG_W-1:0]   tag;
	} slot_t;

endpackage

// ===== rtl/tks_item_if.sv =====
// input item channel
`timescale 1ns / 1ps
interface tks_item_if
	import tks_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      operation;
	logic [POS_W-1:0]     position;
	logic [SCORE_W-1:0]   score;
	logic [TAG_W-1:0]     tag;
	logic [POS_W-1:0]     start_rank;
	logic [COUNT_W-1:0]   want_count;

	modport source (output valid, operation, position, score, tag, start_rank, want_count,
		input ready);
	modport sink (input valid, operation, position, score, tag, start_rank, want_count,
		output ready);
endinterface

// ===== rtl/tks_result_if.sv =====
// result item channel
`timescale 1ns / 1ps
interface tks_result_if
	import tks_pkg::*;
	;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [SCORE_W-1:0]   result_score;
	logic [TAG_W-1:0]     result_tag;
	logic [COUNT_W-1:0]   rank_count;
	logic [COUNT_W-1:0]   filled_count;

	modport source (output valid, status, result_score, result_tag, rank_count,
		filled_count, input ready);
	modport sink (input valid, status, result_score, result_tag, rank_count,
		filled_count, output ready);
endinterface

// ===== rtl/tks_cfg_if.sv =====
// configuration write channel
`timescale 1ns / 1ps
interface tks_cfg_if
	import tks_pkg::*;
	;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tks_ram.sv =====
// single write port, single registered read port memory
`timescale 1ns / 1ps
module tks_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== rtl/top_k_score_selector.sv =====
// top-k score selector: slot table, stable insertion sort and result table
`timescale 1ns / 1ps
// Puts, failed finds and compacts on a full table go straight to the response; a
// read first waits for the registered result table read. A compact walks the active
// slots and moves the filled ones down. A find runs a stable insertion sort through
// the single read port of the slot memory, one score compare at a time, then builds
// the result table from the kept ranks. The input is not ready while an item is in
// work; the finished result sits in an output register so the next item can be taken
// while it waits. Register writes are taken only while idle, and an offered register
// write holds off the item input. Writing table_size empties the table and drops
// the result.
module top_k_score_selector
	import tks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	tks_item_if.sink   item,
	tks_result_if.source result,
	tks_cfg_if.sink    cfg
);
	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int unsigned RST_SIZE = (ENTRIES < 64) ? ENTRIES : 64;

	typedef enum logic [3:0] {
		S_IDLE, S_RD_WAIT, S_CP_CHK, S_CP_WR, S_ST_LOAD, S_ST_HOLD, S_ST_STEP,
		S_ST_CMP, S_CY_CHK, S_CY_WR, S_RESP
	} state_t;

	state_t               state_q;
	logic                 desc_q;
	logic [CW-1:0]        active_q;
	logic [CW-1:0]        fill_q;
	logic [CW-1:0]        kept_q;
	logic                 res_ready_q;
	logic [ENTRIES-1:0]   full_q;
	logic [CW-1:0]        i_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        w_q;
	logic [CW-1:0]        cnt_q;
	logic [POS_W-1:0]     start_q;
	slot_t                hold_q;
	status_t              status_q;
	slot_t                read_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	slot_t                out_slot_q;
	logic [COUNT_W-1:0]   out_kept_q;
	logic [COUNT_W-1:0]   out_fill_q;

	logic                 slot_wr_en;
	logic [AW-1:0]        slot_wr_addr;
	slot_t                slot_wr_data;
	logic [AW-1:0]        slot_rd_addr;
	slot_t                slot_rd_data;
	logic                 rank_wr_en;
	logic [AW-1:0]        rank_wr_addr;
	slot_t                rank_wr_data;
	logic [AW-1:0]        rank_rd_addr;
	slot_t                rank_rd_data;

	logic                 item_acc;
	logic                 cfg_acc;
	logic [AW-1:0]        pos_idx;
	logic                 pos_ok;
	logic                 put_ok;
	logic                 move;
	logic                 out_free;
	logic [XW-1:0]        tsize_x;
	logic [CW-1:0]        tsize_sat;
	logic [CW-1:0]        want_min;

	assign item.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready  = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign out_free   = !out_valid_q || result.ready;

	// decode helpers for the incoming item
	assign pos_idx = AW'(item.position);
	assign pos_ok  = XW'(item.position) < XW'(active_q);
	assign put_ok  = item_acc && (op_t'(item.operation) == OP_PUT) && pos_ok
		&& !full_q[pos_idx];
	assign want_min = (XW'(item.want_count) < XW'(active_q)) ? CW'(item.want_count)
		: active_q;

	// table size saturation to 1..ENTRIES
	assign tsize_x = XW'(cfg.data);
	always_comb begin
		if (tsize_x == '0) begin
			tsize_sat = CW'(1);
		end else if (tsize_x > XW'(ENTRIES)) begin
			tsize_sat = CW'(ENTRIES);
		end else begin
			tsize_sat = CW'(tsize_x);
		end
	end

	// shared compare unit
	assign move = desc_q ? (slot_rd_data.score < hold_q.score)
		: (slot_rd_data.score > hold_q.score);

	// memory port control
	always_comb begin
		slot_wr_en   = 1'b0;
		slot_wr_addr = j_q[AW-1:0];
		slot_wr_data = hold_q;
		slot_rd_addr = i_q[AW-1:0];
		rank_wr_en   = 1'b0;
		rank_wr_addr = i_q[AW-1:0];
		rank_wr_data = slot_rd_data;
		rank_rd_addr = pos_idx;
		unique case (state_q)
			S_IDLE: begin
				slot_wr_en   = put_ok;
				slot_wr_addr = pos_idx;
				slot_wr_data = '{score: item.score, tag: item.tag};
			end
			S_CP_WR: begin
				slot_wr_en   = 1'b1;
				slot_wr_addr = w_q[AW-1:0];
				slot_wr_data = slot_rd_data;
			end
			S_ST_STEP: begin
				slot_wr_en   = (j_q == '0);
				slot_rd_addr = AW'(j_q - CW'(1));
			end
			S_ST_CMP: begin
				slot_wr_en   = 1'b1;
				slot_wr_data = move ? slot_rd_data : hold_q;
			end
			S_CY_CHK: begin
				rank_wr_en   = (i_q != cnt_q) && (XW'(i_q) < XW'(start_q));
				rank_wr_data = '0;
			end
			S_CY_WR: begin
				rank_wr_en   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tks_ram #(.DEPTH(ENTRIES), .WIDTH($bits(slot_t))) u_slot_ram (
		.clk     (clk),
		.wr_en   (slot_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.rd_addr (slot_rd_addr),
		.rd_data (slot_rd_data)
	);

	tks_ram #(.DEPTH(ENTRIES), .WIDTH($bits(slot_t))) u_rank_ram (
		.clk     (clk),
		.wr_en   (rank_wr_en),
		.wr_addr (rank_wr_addr),
		.wr_data (rank_wr_data),
		.rd_addr (rank_rd_addr),
		.rd_data (rank_rd_data)
	);

	// sequencer, table state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			desc_q       <= 1'b0;
			active_q     <= CW'(RST_SIZE);
			fill_q       <= '0;
			kept_q       <= '0;
			res_ready_q  <= 1'b0;
			full_q       <= '0;
			i_q          <= '0;
			j_q          <= '0;
			w_q          <= '0;
			cnt_q        <= '0;
			start_q      <= '0;
			status_q     <= ST_OK;
			out_valid_q  <= 1'b0;
		end else begin
			// result loaded, or handed over
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			// register writes, only while idle
			if (cfg_acc) begin
				unique case (reg_idx_t'(cfg.index))
					REG_SORT_DESC: desc_q <= cfg.data[0];
					REG_TABLE_SIZE: begin
						active_q    <= tsize_sat;
						fill_q      <= '0;
						full_q      <= '0;
						kept_q      <= '0;
						res_ready_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					read_q <= '0;
					if (item_acc) begin
						status_q <= ST_OK;
						state_q  <= S_RESP;
						unique case (op_t'(item.operation))
							OP_PUT: begin
								kept_q      <= '0;
								res_ready_q <= 1'b0;
								if (!pos_ok) begin
									status_q <= ST_SLOT_RANGE;
								end else if (full_q[pos_idx]) begin
									status_q <= ST_SLOT_FILLED;
								end else begin
									full_q[pos_idx] <= 1'b1;
									fill_q <= CW'(fill_q + CW'(1));
								end
							end
							OP_COMPACT: begin
								if (fill_q != active_q) begin
									i_q     <= '0;
									w_q     <= '0;
									state_q <= S_CP_CHK;
								end
							end
							OP_FIND: begin
								if (fill_q != active_q) begin
									status_q <= ST_NOT_FULL;
								end else if (XW'(item.start_rank) >= XW'(active_q)) begin
									status_q <= ST_START_LARGE;
								end else begin
									cnt_q   <= want_min;
									start_q <= item.start_rank;
									i_q     <= CW'(1);
									state_q <= S_ST_LOAD;
								end
							end
							OP_READ: begin
								if (!res_ready_q) begin
									status_q <= ST_NO_RESULT;
								end else if (XW'(item.position) >= XW'(kept_q)) begin
									status_q <= ST_INDEX_LARGE;
								end else begin
									state_q <= S_RD_WAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD_WAIT: begin
					read_q  <= rank_rd_data;
					state_q <= S_RESP;
				end
				// compact: walk the active slots, move filled ones down
				S_CP_CHK: begin
					if (i_q == active_q) begin
						for (int k = 0; k < ENTRIES; k++) begin
							full_q[k] <= (CW'(k) < w_q);
						end
						active_q <= w_q;
						fill_q   <= w_q;
						state_q  <= S_RESP;
					end else if (full_q[i_q[AW-1:0]]) begin
						state_q <= S_CP_WR;
					end else begin
						i_q <= CW'(i_q + CW'(1));
					end
				end
				S_CP_WR: begin
					w_q     <= CW'(w_q + CW'(1));
					i_q     <= CW'(i_q + CW'(1));
					state_q <= S_CP_CHK;
				end
				// insertion sort: take slot i, shift larger entries up (smaller ones when descending)
				S_ST_LOAD: begin
					if (i_q >= active_q) begin
						i_q     <= '0;
						state_q <= S_CY_CHK;
					end else begin
						state_q <= S_ST_HOLD;
					end
				end
				S_ST_HOLD: begin
					hold_q  <= slot_rd_data;
					j_q     <= i_q;
					state_q <= S_ST_STEP;
				end
				S_ST_STEP: begin
					if (j_q == '0) begin
						i_q     <= CW'(i_q + CW'(1));
						state_q <= S_ST_LOAD;
					end else begin
						state_q <= S_ST_CMP;
					end
				end
				S_ST_CMP: begin
					if (move) begin
						j_q     <= CW'(j_q - CW'(1));
						state_q <= S_ST_STEP;
					end else begin
						i_q     <= CW'(i_q + CW'(1));
						state_q <= S_ST_LOAD;
					end
				end
				// build the result table from the sorted slots
				S_CY_CHK: begin
					if (i_q == cnt_q) begin
						kept_q      <= cnt_q;
						res_ready_q <= 1'b1;
						state_q     <= S_RESP;
					end else if (XW'(i_q) < XW'(start_q)) begin
						i_q <= CW'(i_q + CW'(1));
					end else begin
						state_q <= S_CY_WR;
					end
				end
				S_CY_WR: begin
					i_q     <= CW'(i_q + CW'(1));
					state_q <= S_CY_CHK;
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= status_q;
						out_slot_q   <= read_q;
						out_kept_q   <= COUNT_W'(kept_q);
						out_fill_q   <= COUNT_W'(fill_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result port
	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.result_score = out_slot_q.score;
	assign result.result_tag   = out_slot_q.tag;
	assign result.rank_count   = out_kept_q;
	assign result.filled_count = out_fill_q;
endmodule
